@@ design/rpht_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpht_pkg: shared types and constants for the regular polygon hit test
// Field widths, fixed-point constants, register index codes and the
// whole-degree Q1.15 sine table with its quadrant folding function.
// ----------------------------------------------------------------------------
package rpht_pkg;

  // Field and datapath widths
  localparam int unsigned DATA_W    = 24;  // point and centre coordinates
  localparam int unsigned RAD_W     = 23;  // circumradius
  localparam int unsigned SIDE_W    = 7;   // side count register
  localparam int unsigned CFG_IDX_W = 3;   // configuration register index
  localparam int unsigned VTX_W     = 25;  // vertex coordinate
  localparam int unsigned MUL_W     = 26;  // shared multiplier operand
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned ANG_W     = 9;   // whole degrees 0..449
  localparam int unsigned TRIG_W    = 17;  // signed Q1.15
  localparam int unsigned MAG_W     = 16;  // table magnitude
  localparam int unsigned TAB_IDX_W = 7;   // table index 0..90

  // Angle and fixed-point constants
  localparam int unsigned FULL_TURN    = 360;
  localparam int unsigned HALF_TURN    = 180;
  localparam int unsigned QUARTER_TURN = 90;
  localparam int unsigned THREE_QUARTER_TURN = 270;
  localparam int unsigned Q15_FRAC     = 15;
  localparam int unsigned ROUND_HALF   = 16384;

  // Side count limits
  localparam int unsigned SIDE_MIN      = 3;
  localparam int unsigned MAX_SIDES_DEF = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CIRCUM_RADIUS = 3'd2,
    REG_SIDE_COUNT    = 3'd3
  } cfg_reg_e;

  // round(32768 * sin(d)) for d = 0..90, full scale clamped
  localparam logic [MAG_W-1:0] SIN_TAB [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,
    16'd3425,  16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,
    16'd6813,  16'd7371,  16'd7927,  16'd8481,  16'd9032,  16'd9580,
    16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275, 16'd12803,
    16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
    16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795,
    16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965,
    16'd24351, 16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170,
    16'd26510, 16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
    16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452, 16'd29698,
    16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
    16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928,
    16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
    16'd32767
  };

  // Signed Q1.15 sine of a whole-degree angle below a full turn
  function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [ANG_W-1:0] d);
    logic [ANG_W-1:0] idx;
    logic             neg;
    logic [MAG_W-1:0] mag;
    if (d <= ANG_W'(QUARTER_TURN)) begin
      idx = d;
      neg = 1'b0;
    end else if (d <= ANG_W'(HALF_TURN)) begin
      idx = ANG_W'(HALF_TURN) - d;
      neg = 1'b0;
    end else if (d <= ANG_W'(THREE_QUARTER_TURN)) begin
      idx = d - ANG_W'(HALF_TURN);
      neg = 1'b1;
    end else begin
      idx = ANG_W'(FULL_TURN) - d;
      neg = 1'b1;
    end
    mag = SIN_TAB[idx[TAB_IDX_W-1:0]];
    if (neg) begin
      sin_deg = -$signed({1'b0, mag});
    end else begin
      sin_deg = $signed({1'b0, mag});
    end
  endfunction

endpackage
`default_nettype wire

@@ design/rpht_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpht_mul: shared signed multiplier
// Registered operands (op_a_q, op_b_q) and registered product (prod_q).
// ----------------------------------------------------------------------------
module rpht_mul (
  input  wire logic                                 clk_i,
  input  wire logic signed [rpht_pkg::MUL_W-1:0]    a_i,
  input  wire logic signed [rpht_pkg::MUL_W-1:0]    b_i,
  output logic signed      [rpht_pkg::PROD_W-1:0]   prod_o
);

  logic signed [rpht_pkg::MUL_W-1:0]  op_a_q;
  logic signed [rpht_pkg::MUL_W-1:0]  op_b_q;
  logic signed [rpht_pkg::PROD_W-1:0] prod_q;

  // Capture operands, then multiply
  always_ff @(posedge clk_i) begin
    op_a_q <= a_i;
    op_b_q <= b_i;
    prod_q <= op_a_q * op_b_q;
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

@@ design/rpht_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpht_div: angle step divider
// Restoring divider for a full turn divided by the side count, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpht_div #(
  parameter int unsigned NW = 7
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [NW-1:0]                   divisor_i,
  output logic                                 done_o,
  output logic [rpht_pkg::ANG_W-1:0]           quot_o
);

  localparam int unsigned CW = $clog2(rpht_pkg::ANG_W);

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [NW-1:0]     rem_q;
  logic [rpht_pkg::ANG_W-1:0] quo_q;
  logic [NW:0]       trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[rpht_pkg::ANG_W-1]};
  assign fits  = (trial >= {1'b0, divisor_i});

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(rpht_pkg::ANG_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= rpht_pkg::ANG_W'(rpht_pkg::FULL_TURN);
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= NW'(trial - {1'b0, divisor_i});
      end else begin
        rem_q <= NW'(trial);
      end
      quo_q <= {quo_q[rpht_pkg::ANG_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

@@ design/regular_polygon_hit_test.sv @@
// Items are taken one at a time, only while the sequencer is idle; the next item
//   is taken while a result waits in the output register.
// Reset: asynchronous, active low; registers return to centre 0, radius 0, 3 sides.
`default_nettype none
// ----------------------------------------------------------------------------
// regular_polygon_hit_test: crossing-number test against a regular polygon
// Builds each vertex from the sine table through a shared multiplier and tests each
// edge straddling the point's y by cross-multiplication; reports crossing parity.
// ----------------------------------------------------------------------------
module regular_polygon_hit_test #(
  parameter int unsigned MAX_SIDES = rpht_pkg::MAX_SIDES_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [rpht_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [rpht_pkg::DATA_W-1:0]             cfg_data_i,
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic signed [rpht_pkg::DATA_W-1:0]      point_x_i,
  input  wire logic signed [rpht_pkg::DATA_W-1:0]      point_y_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic                                         inside_res_o
);

  localparam int unsigned SIDE_CAP = (MAX_SIDES < 127) ? MAX_SIDES : 127;
  localparam int unsigned NW       = $clog2(SIDE_CAP + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'h001,
    S_DIV   = 12'h002,
    S_VX    = 12'h004,
    S_VY    = 12'h008,
    S_VXS   = 12'h010,
    S_VYS   = 12'h020,
    S_DIFF  = 12'h040,
    S_DIFF2 = 12'h080,
    S_MUL   = 12'h100,
    S_CMP   = 12'h200,
    S_ADV   = 12'h400,
    S_DONE  = 12'h800
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic signed [rpht_pkg::DATA_W-1:0] cx_q, cy_q;
  logic [rpht_pkg::RAD_W-1:0]         rad_q;
  logic [rpht_pkg::SIDE_W-1:0]        side_q;

  // Item state
  logic signed [rpht_pkg::DATA_W-1:0] px_q, py_q;
  logic signed [rpht_pkg::VTX_W-1:0]  x1_q, y1_q, x2_q, y2_q, v0x_q, v0y_q;
  logic [rpht_pkg::ANG_W-1:0]         ang_q, step_q;
  logic signed [rpht_pkg::PROD_W-1:0] lhs_q;
  logic [NW-1:0]                      k_q, n_q, n_eff;
  logic                               first_q, dy_pos_q, parity_q;
  logic                               out_valid_q, res_q;

  // Shared units and datapath nets
  logic signed [rpht_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [rpht_pkg::PROD_W-1:0] prod;
  logic signed [rpht_pkg::PROD_W-1:0] prod_rnd, prod_scl;
  logic signed [rpht_pkg::VTX_W-1:0]  v_new;
  logic [rpht_pkg::ANG_W-1:0]         cos_ang, cos_sum;
  logic                               div_done;
  logic [rpht_pkg::ANG_W-1:0]         div_quot;
  logic                               in_xfer, out_free, straddle, hit;
  logic                               last_edge, next_closes;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign inside_res_o = res_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Clamp the side count into the supported range
  always_comb begin
    if (side_q < rpht_pkg::SIDE_W'(rpht_pkg::SIDE_MIN)) begin
      n_eff = NW'(rpht_pkg::SIDE_MIN);
    end else if (32'(side_q) > SIDE_CAP) begin
      n_eff = NW'(SIDE_CAP);
    end else begin
      n_eff = NW'(side_q);
    end
  end

  // Step angle from the divider
  rpht_div #(.NW(NW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_xfer),
    .divisor_i (n_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Cosine is the sine a quarter turn on
  assign cos_sum = ang_q + rpht_pkg::ANG_W'(rpht_pkg::QUARTER_TURN);
  assign cos_ang = (cos_sum >= rpht_pkg::ANG_W'(rpht_pkg::FULL_TURN)) ?
                   cos_sum - rpht_pkg::ANG_W'(rpht_pkg::FULL_TURN) : cos_sum;

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_VX: begin
        mul_a = $signed({{(rpht_pkg::MUL_W - rpht_pkg::RAD_W){1'b0}}, rad_q});
        mul_b = rpht_pkg::MUL_W'(rpht_pkg::sin_deg(cos_ang));
      end
      S_VY: begin
        mul_a = $signed({{(rpht_pkg::MUL_W - rpht_pkg::RAD_W){1'b0}}, rad_q});
        mul_b = rpht_pkg::MUL_W'(rpht_pkg::sin_deg(ang_q));
      end
      S_DIFF: begin
        mul_a = rpht_pkg::MUL_W'(px_q) - rpht_pkg::MUL_W'(x1_q);
        mul_b = rpht_pkg::MUL_W'(y2_q) - rpht_pkg::MUL_W'(y1_q);
      end
      S_DIFF2: begin
        mul_a = rpht_pkg::MUL_W'(py_q) - rpht_pkg::MUL_W'(y1_q);
        mul_b = rpht_pkg::MUL_W'(x2_q) - rpht_pkg::MUL_W'(x1_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rpht_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Round the scaled trig product half up and add the centre
  assign prod_rnd = prod + rpht_pkg::PROD_W'(rpht_pkg::ROUND_HALF);
  assign prod_scl = prod_rnd >>> rpht_pkg::Q15_FRAC;
  assign v_new    = rpht_pkg::VTX_W'(prod_scl) +
                    ((state_q == S_VXS) ? rpht_pkg::VTX_W'(cx_q) : rpht_pkg::VTX_W'(cy_q));

  // Edge tests
  assign straddle    = ((py_q < y1_q) != (py_q < y2_q));
  assign hit         = dy_pos_q ? (lhs_q < prod) : (lhs_q > prod);
  assign last_edge   = (k_q == n_q - NW'(1));
  assign next_closes = ((k_q + NW'(1)) == (n_q - NW'(1)));

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_VX;
      S_VX:    state_d = S_VY;
      S_VY:    state_d = S_VXS;
      S_VXS:   state_d = S_VYS;
      S_VYS:   state_d = first_q ? S_VX : S_DIFF;
      S_DIFF:  state_d = straddle ? S_DIFF2 : S_ADV;
      S_DIFF2: state_d = S_MUL;
      S_MUL:   state_d = S_CMP;
      S_CMP:   state_d = S_ADV;
      S_ADV: begin
        if (last_edge) begin
          state_d = S_DONE;
        end else if (next_closes) begin
          state_d = S_DIFF;
        end else begin
          state_d = S_VX;
        end
      end
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      n_q         <= NW'(rpht_pkg::SIDE_MIN);
      first_q     <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        k_q      <= '0;
        n_q      <= n_eff;
        first_q  <= 1'b1;
        parity_q <= 1'b0;
      end
      if (state_q == S_VYS) begin
        first_q <= 1'b0;
      end
      if (state_q == S_CMP && hit) begin
        parity_q <= !parity_q;
      end
      if (state_q == S_ADV && !last_edge) begin
        k_q <= k_q + NW'(1);
      end
      // Raise the result when a new one lands, drop it on its transfer
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      rad_q  <= '0;
      side_q <= rpht_pkg::SIDE_W'(rpht_pkg::SIDE_MIN);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rpht_pkg::REG_CENTER_X:      cx_q   <= $signed(cfg_data_i);
        rpht_pkg::REG_CENTER_Y:      cy_q   <= $signed(cfg_data_i);
        rpht_pkg::REG_CIRCUM_RADIUS: rad_q  <= cfg_data_i[rpht_pkg::RAD_W-1:0];
        rpht_pkg::REG_SIDE_COUNT:    side_q <= cfg_data_i[rpht_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q  <= point_x_i;
      py_q  <= point_y_i;
      ang_q <= '0;
    end
    if (state_q == S_DIV && div_done) begin
      step_q <= div_quot;
    end
    if (state_q == S_VXS) begin
      x2_q <= v_new;
    end
    if (state_q == S_VYS) begin
      if (first_q) begin
        x1_q  <= x2_q;
        y1_q  <= v_new;
        v0x_q <= x2_q;
        v0y_q <= v_new;
        ang_q <= ang_q + step_q;
      end else begin
        y2_q <= v_new;
      end
    end
    if (state_q == S_DIFF) begin
      dy_pos_q <= (y2_q > y1_q);
    end
    if (state_q == S_MUL) begin
      lhs_q <= prod;
    end
    // Advance: the end vertex becomes the start of the next edge
    if (state_q == S_ADV && !last_edge) begin
      x1_q  <= x2_q;
      y1_q  <= y2_q;
      ang_q <= ang_q + step_q;
      if (next_closes) begin
        x2_q <= v0x_q;
        y2_q <= v0y_q;
      end
    end
    if (state_q == S_DONE && out_free) begin
      res_q <= parity_q;
    end
  end

  // Edge index never passes the side count
  a_edge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q < n_q)
    else $error("edge index out of range");

  // Vertex angles stay below a full turn
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VX) |-> (ang_q < rpht_pkg::ANG_W'(rpht_pkg::FULL_TURN)))
    else $error("vertex angle past a full turn");

  // A zero radius collapses all vertices, so no edge straddles
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIFF2) |-> (rad_q != '0))
    else $error("straddling edge with zero radius");

  // An accepted item always starts with the step division
  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_DIV))
    else $error("item did not enter the divide step");

endmodule
`default_nettype wire
